// ----- src/utf8d_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants of the UTF-8 validating decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

   localparam int unsigned CpWidth    = 21;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned UsedWidth  = 3;
   localparam int unsigned CountWidth = 3;
   localparam int unsigned LenWidth   = 3;
   localparam int unsigned TrailWidth = 2;

   localparam logic [CpWidth-1:0] REPLACEMENT_CHAR = 21'h00FFFD;

   // results caused by one input byte: count minus one copies of the
   // replacement transaction, then the final one described here
   typedef struct packed {
      logic [CountWidth-1:0] count;
      logic [CpWidth-1:0]    scalar_value;
      logic                  replaced;
      logic [UsedWidth-1:0]  bytes_used;
   } burst_type;

endpackage

`default_nettype wire

// ----- src/utf8d_core.sv -----
// ----------------------------------------------------------------------------
// utf8d_core
// Sequence state and the per-byte decode step that yields a result burst.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              accept,
   input  wire logic [utf8d_pkg::ByteWidth-1:0]   byte_value,
   input  wire logic                              end_of_buffer,
   output utf8d_pkg::burst_type                   burst
);
   import utf8d_pkg::*;

   logic [LenWidth-1:0]   expected_length_ff, expected_length_in;
   logic [TrailWidth-1:0] trails_gathered_ff, trails_gathered_in;
   logic [CpWidth-1:0]    partial_value_ff, partial_value_in;

   logic                  is_cont;
   logic [CpWidth-1:0]    shifted_value;
   logic [TrailWidth-1:0] next_trails;
   logic [CountWidth-1:0] rep_count;
   logic                  final_valid;
   logic                  handle_lead;
   logic [LenWidth-1:0]   lead_len;
   logic [CpWidth-1:0]    lead_bits;

   assign is_cont       = (byte_value[7:6] == 2'b10);
   assign shifted_value = {partial_value_ff[CpWidth-7:0], byte_value[5:0]};
   assign next_trails   = trails_gathered_ff + 2'd1;

   always_comb begin
      lead_len  = '0;
      lead_bits = '0;
      if ((byte_value & 8'hE0) == 8'hC0) begin
         lead_len  = 3'd2;
         lead_bits = CpWidth'(byte_value & 8'h1F);
      end else if ((byte_value & 8'hF0) == 8'hE0) begin
         lead_len  = 3'd3;
         lead_bits = CpWidth'(byte_value & 8'h0F);
      end else if ((byte_value & 8'hF8) == 8'hF0) begin
         lead_len  = 3'd4;
         lead_bits = CpWidth'(byte_value & 8'h07);
      end
   end

   always_comb begin
      expected_length_in = expected_length_ff;
      trails_gathered_in = trails_gathered_ff;
      partial_value_in   = partial_value_ff;
      rep_count          = '0;
      final_valid        = 1'b0;
      handle_lead        = 1'b1;
      burst.scalar_value = REPLACEMENT_CHAR;
      burst.replaced     = 1'b1;
      burst.bytes_used   = 3'd1;

      if (expected_length_ff != '0) begin
         if (is_cont) begin
            handle_lead = 1'b0;
            if ({1'b0, next_trails} + 3'd1 >= expected_length_ff) begin
               final_valid        = 1'b1;
               burst.scalar_value = shifted_value;
               burst.replaced     = 1'b0;
               burst.bytes_used   = expected_length_ff;
               expected_length_in = '0;
               trails_gathered_in = '0;
               partial_value_in   = '0;
            end else begin
               trails_gathered_in = next_trails;
               partial_value_in   = shifted_value;
               if (end_of_buffer) begin
                  rep_count = {1'b0, next_trails} + 3'd1;
               end
            end
         end else begin
            // broken sequence: replace lead and trails, then treat as a lead
            rep_count          = {1'b0, trails_gathered_ff} + 3'd1;
            expected_length_in = '0;
            trails_gathered_in = '0;
            partial_value_in   = '0;
         end
      end

      if (handle_lead) begin
         if (!byte_value[7]) begin
            final_valid        = 1'b1;
            burst.scalar_value = CpWidth'(byte_value);
            burst.replaced     = 1'b0;
            burst.bytes_used   = 3'd1;
         end else if (lead_len == '0 || end_of_buffer) begin
            final_valid = 1'b1;
         end else begin
            expected_length_in = lead_len;
            trails_gathered_in = '0;
            partial_value_in   = lead_bits;
         end
      end

      if (end_of_buffer) begin
         expected_length_in = '0;
         trails_gathered_in = '0;
         partial_value_in   = '0;
      end

      burst.count = rep_count + {2'b00, final_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_length_ff <= '0;
         trails_gathered_ff <= '0;
         partial_value_ff   <= '0;
      end else if (accept) begin
         expected_length_ff <= expected_length_in;
         trails_gathered_ff <= trails_gathered_in;
         partial_value_ff   <= partial_value_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/utf8d_burst.sv -----
// ----------------------------------------------------------------------------
// utf8d_burst
// Result register that plays out one burst of decoder results.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_burst (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              load,
   input  wire utf8d_pkg::burst_type              burst,
   output logic                                   load_ok,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [utf8d_pkg::CpWidth-1:0]          rsp_scalar_value,
   output logic                                   rsp_replaced,
   output logic [utf8d_pkg::UsedWidth-1:0]        rsp_bytes_used,
   output logic                                   rsp_last_of_run
);
   import utf8d_pkg::*;

   logic [CountWidth-1:0] count_ff, count_in;
   logic [CpWidth-1:0]    scalar_ff, scalar_in;
   logic                  replaced_ff, replaced_in;
   logic [UsedWidth-1:0]  bytes_used_ff, bytes_used_in;
   logic                  is_last;
   logic                  fire;

   assign is_last   = (count_ff == 3'd1);
   assign rsp_valid = (count_ff != '0);
   assign fire      = rsp_valid && rsp_ready;
   // a new burst may load in the cycle the last result of the old one leaves
   assign load_ok   = (count_ff == '0) || (is_last && rsp_ready);

   assign rsp_scalar_value = is_last ? scalar_ff     : REPLACEMENT_CHAR;
   assign rsp_replaced     = is_last ? replaced_ff   : 1'b1;
   assign rsp_bytes_used   = is_last ? bytes_used_ff : 3'd1;
   assign rsp_last_of_run  = is_last;

   always_comb begin
      count_in      = count_ff;
      scalar_in     = scalar_ff;
      replaced_in   = replaced_ff;
      bytes_used_in = bytes_used_ff;
      if (fire) begin
         count_in = count_ff - 3'd1;
      end
      if (load) begin
         count_in      = burst.count;
         scalar_in     = burst.scalar_value;
         replaced_in   = burst.replaced;
         bytes_used_in = burst.bytes_used;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      scalar_ff     <= scalar_in;
      replaced_ff   <= replaced_in;
      bytes_used_ff <= bytes_used_in;
   end

endmodule

`default_nettype wire

// ----- src/utf8_validating_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_validating_decoder
// UTF-8 byte stream decoder with U+FFFD replacement of invalid input.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while req_ready is high. Each byte yields
// zero to four results: a decoded code point when a sequence completes, or
// U+FFFD for each byte of a broken, truncated or illegal sequence. Results
// leave one per cycle from an output register while rsp_ready is high, and
// the next byte is taken in the same cycle as the last result of the
// previous byte, so plain text streams at one byte per clock. A byte that
// breaks an open sequence yields U+FFFD for its lead and each trail, then
// is decoded anew; req_ready stays low until its last result leaves.
// Overlong forms and surrogates decode arithmetically and are not flagged.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_validating_decoder (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [utf8d_pkg::ByteWidth-1:0]   req_byte_value,
   input  wire logic                              req_end_of_buffer,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [utf8d_pkg::CpWidth-1:0]          rsp_scalar_value,
   output logic                                   rsp_replaced,
   output logic [utf8d_pkg::UsedWidth-1:0]        rsp_bytes_used,
   output logic                                   rsp_last_of_run
);
   import utf8d_pkg::*;

   burst_type burst;
   logic      load_ok;
   logic      accept;

   assign req_ready = load_ok;
   assign accept    = req_valid && load_ok;

   utf8d_core u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .byte_value    (req_byte_value),
      .end_of_buffer (req_end_of_buffer),
      .burst         (burst)
   );

   utf8d_burst u_burst (
      .clock            (clock),
      .reset            (reset),
      .load             (accept),
      .burst            (burst),
      .load_ok          (load_ok),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_scalar_value (rsp_scalar_value),
      .rsp_replaced     (rsp_replaced),
      .rsp_bytes_used   (rsp_bytes_used),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

`default_nettype wire
